// ----- rtl/fbc_pkg.sv -----
// Shared types and constants for the frustum box cull block.
`timescale 1ns / 1ps
package fbc_pkg;

  // Fixed-point format of the normals and the distance arithmetic
  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 16;
  localparam int OFFSET_W  = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int DOT_W     = 35;
  localparam int DIST_W    = 34;

  // Item codes
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_TEST = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
  localparam logic [1:0] VERDICT_INSIDE    = 2'd1;
  localparam logic [1:0] VERDICT_INTERSECT = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OFFSET_W-1:0] offset_t;

  // Index 0 is x, 1 is y, 2 is z
  typedef coord_t [2:0] vec3_t;

  // Load enables of the lane pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // Per-plane result of one box test
  typedef struct packed {
    logic pos_neg;  // positive corner lies behind the plane
    logic neg_neg;  // negative corner lies behind the plane
  } lane_flags_t;

endpackage

// ----- rtl/fbc_plane_store.sv -----
// Plane register file: write decode for loads, all planes read in parallel.
`timescale 1ns / 1ps
module fbc_plane_store #(
  parameter int PLANE_COUNT = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  fbc_pkg::vec3_t    wr_normal,
  input  fbc_pkg::offset_t  wr_offset,
  output fbc_pkg::vec3_t    normals [PLANE_COUNT],
  output fbc_pkg::offset_t  offsets [PLANE_COUNT]
);
  import fbc_pkg::*;

  // One register set per plane; an out-of-range index matches no entry
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    always_ff @(posedge clk) begin
      if (rst) begin
        normals[p] <= '0;
        offsets[p] <= '0;
      end else if (wr_en && ({1'b0, wr_index} == 4'(p))) begin
        normals[p] <= wr_normal;
        offsets[p] <= wr_offset;
      end
    end
  end

endmodule

// ----- rtl/fbc_lane.sv -----
// One plane lane: corner pick, products, dot sums, distance sign.
`timescale 1ns / 1ps
module fbc_lane (
  input  logic                 clk,
  input  fbc_pkg::stage_en_t   en,
  input  fbc_pkg::vec3_t       normal,
  input  fbc_pkg::offset_t     offset,
  input  fbc_pkg::vec3_t       box_lo,
  input  fbc_pkg::vec3_t       box_hi,
  output fbc_pkg::lane_flags_t flags
);
  import fbc_pkg::*;

  vec3_t                      pc1, nc1, n1;
  offset_t                    off1, off2, off3;
  logic signed [PROD_W-1:0]   pp2 [3];
  logic signed [PROD_W-1:0]   np2 [3];
  logic signed [DOT_W-1:0]    pdot3, ndot3;
  logic signed [DIST_W-1:0]   pdist, ndist;

  // Stage 1: normal signs pick the positive and negative corners
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int k = 0; k < 3; k++) begin
        pc1[k] <= normal[k][COORD_W-1] ? box_lo[k] : box_hi[k];
        nc1[k] <= normal[k][COORD_W-1] ? box_hi[k] : box_lo[k];
      end
      n1   <= normal;
      off1 <= offset;
    end
  end

  // Stage 2: six 16x16 products
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int k = 0; k < 3; k++) begin
        pp2[k] <= $signed(pc1[k]) * $signed(n1[k]);
        np2[k] <= $signed(nc1[k]) * $signed(n1[k]);
      end
      off2 <= off1;
    end
  end

  // Stage 3: exact dot sums
  always_ff @(posedge clk) begin
    if (en.s3) begin
      pdot3 <= DOT_W'(pp2[0]) + DOT_W'(pp2[1]) + DOT_W'(pp2[2]);
      ndot3 <= DOT_W'(np2[0]) + DOT_W'(np2[1]) + DOT_W'(np2[2]);
      off3  <= off2;
    end
  end

  // Stage 4: floor shift, add offset, keep the sign
  assign pdist = DIST_W'(pdot3 >>> FRAC_BITS) + DIST_W'($signed(off3));
  assign ndist = DIST_W'(ndot3 >>> FRAC_BITS) + DIST_W'($signed(off3));

  always_ff @(posedge clk) begin
    if (en.s4) begin
      flags.pos_neg <= pdist[DIST_W-1];
      flags.neg_neg <= ndist[DIST_W-1];
    end
  end

endmodule

// ----- rtl/frustum_box_cull.sv -----
// Top level of the frustum box cull block: handshakes, stage control, verdict.
`timescale 1ns / 1ps
// Tests axis-aligned boxes against up to PLANE_COUNT stored frustum planes.
// A load beat (action 0) writes one plane in the cycle it is taken and gives
// no result; an index at or above PLANE_COUNT is dropped. A test beat
// (action 1) gives one verdict: outside, intersect or inside. Tests use the
// planes as they stand when the beat is taken, so loads and tests may be
// mixed freely. The block takes one beat per cycle while in_ready is high; a
// verdict reaches the output register through a five-stage pipeline
// (corner pick, multipliers, dot sums, distance sign, verdict merge) with one
// lane of multipliers per plane. Stalls on the output fill the pipeline's
// empty slots before input stops.
module frustum_box_cull #(
  parameter int PLANE_COUNT = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic [2:0]                plane_index,
  input  logic signed [15:0]        normal_x,
  input  logic signed [15:0]        normal_y,
  input  logic signed [15:0]        normal_z,
  input  logic signed [31:0]        plane_offset,
  input  logic signed [15:0]        box_min_x,
  input  logic signed [15:0]        box_min_y,
  input  logic signed [15:0]        box_min_z,
  input  logic signed [15:0]        box_max_x,
  input  logic signed [15:0]        box_max_y,
  input  logic signed [15:0]        box_max_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                verdict
);
  import fbc_pkg::*;

  logic        in_beat;
  logic        load_wr;
  vec3_t       wr_normal, box_lo, box_hi;
  vec3_t       normals [PLANE_COUNT];
  offset_t     offsets [PLANE_COUNT];
  lane_flags_t lane_flags [PLANE_COUNT];
  logic [PLANE_COUNT-1:0] pos_neg, neg_neg;

  logic        s1_valid, s2_valid, s3_valid, s4_valid;
  logic        r1, r2, r3, r4, r5;
  stage_en_t   en;
  logic [1:0]  verdict_next;

  assign wr_normal = {normal_z, normal_y, normal_x};
  assign box_lo    = {box_min_z, box_min_y, box_min_x};
  assign box_hi    = {box_max_z, box_max_y, box_max_x};

  // Ready chain: a stage takes new data when empty or when it moves on
  assign r5 = !out_valid || out_ready;
  assign r4 = !s4_valid  || r5;
  assign r3 = !s3_valid  || r4;
  assign r2 = !s2_valid  || r3;
  assign r1 = !s1_valid  || r2;
  assign in_ready = r1;
  assign in_beat  = in_valid && in_ready;

  assign en.s1 = r1;
  assign en.s2 = r2;
  assign en.s3 = r3;
  assign en.s4 = r4;

  // Plane writes; out-of-range indexes are dropped
  assign load_wr = in_beat && (action == ACTION_LOAD)
                   && ({1'b0, plane_index} < 4'(PLANE_COUNT));

  fbc_plane_store #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (load_wr),
    .wr_index  (plane_index),
    .wr_normal (wr_normal),
    .wr_offset (plane_offset),
    .normals   (normals),
    .offsets   (offsets)
  );

  // One lane per plane
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    fbc_lane u_lane (
      .clk    (clk),
      .en     (en),
      .normal (normals[p]),
      .offset (offsets[p]),
      .box_lo (box_lo),
      .box_hi (box_hi),
      .flags  (lane_flags[p])
    );
    assign pos_neg[p] = lane_flags[p].pos_neg;
    assign neg_neg[p] = lane_flags[p].neg_neg;
  end

  // Valid bits travel with the test beats
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) s1_valid  <= in_valid && (action == ACTION_TEST);
      if (r2) s2_valid  <= s1_valid;
      if (r3) s3_valid  <= s2_valid;
      if (r4) s4_valid  <= s3_valid;
      if (r5) out_valid <= s4_valid;
    end
  end

  // Merge: any positive corner behind wins over any negative corner behind
  always_comb begin
    priority if (|pos_neg) begin
      verdict_next = VERDICT_OUTSIDE;
    end else if (|neg_neg) begin
      verdict_next = VERDICT_INTERSECT;
    end else begin
      verdict_next = VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      verdict <= verdict_next;
    end
  end

`ifndef SYNTHESIS
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == VERDICT_OUTSIDE || verdict == VERDICT_INSIDE
                   || verdict == VERDICT_INTERSECT))
    else $error("verdict holds an unused code");

  a_test_enters: assert property (@(posedge clk) disable iff (rst)
    (in_beat && action == ACTION_TEST) |=> s1_valid)
    else $error("accepted test beat did not enter the pipeline");

  a_load_no_slot: assert property (@(posedge clk) disable iff (rst)
    (in_beat && action == ACTION_LOAD) |=> !s1_valid)
    else $error("load beat took a pipeline slot");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && out_valid && !out_ready) |=> s4_valid)
    else $error("stage 4 beat lost during an output stall");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the frustum box cull block.
`timescale 1ns / 1ps
module tb;
  import fbc_pkg::*;

  localparam int PLANES      = 5;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int BEAT_TARGET = 1350;
  localparam int DRAIN_CYCLES = 12;

  // One input beat as it appears on the ports
  typedef struct packed {
    logic       action;
    logic [2:0] plane_index;
    vec3_t      normal;
    offset_t    offset;
    vec3_t      lo;
    vec3_t      hi;
  } cull_beat_t;

  // Plane store mirror and queue of verdicts still owed by the block
  class cull_scoreboard;
    longint     nrm[PLANES][3];
    longint     ofs[PLANES];
    logic [1:0] verdict_q[$];
    int         mismatches;

    function new();
      int p, k;
      for (p = 0; p < PLANES; p++) begin
        for (k = 0; k < 3; k++) nrm[p][k] = 0;
        ofs[p] = 0;
      end
      mismatches = 0;
    endfunction

    // n-vertex / p-vertex test of one box against every stored plane
    function logic [1:0] classify_box(cull_beat_t b);
      logic [1:0] v;
      longint lo[3], hi[3], pc[3], nc[3];
      longint dist_pos, dist_neg;
      int p, k;
      v = VERDICT_INSIDE;
      for (k = 0; k < 3; k++) begin
        lo[k] = longint'($signed(b.lo[k]));
        hi[k] = longint'($signed(b.hi[k]));
      end
      for (p = 0; p < PLANES; p++) begin
        for (k = 0; k < 3; k++) begin
          pc[k] = (nrm[p][k] < 0) ? lo[k] : hi[k];
          nc[k] = (nrm[p][k] < 0) ? hi[k] : lo[k];
        end
        dist_pos = ((pc[0] * nrm[p][0] + pc[1] * nrm[p][1] + pc[2] * nrm[p][2]) >>> 8)
                   + ofs[p];
        if (dist_pos < 0) return VERDICT_OUTSIDE;
        dist_neg = ((nc[0] * nrm[p][0] + nc[1] * nrm[p][1] + nc[2] * nrm[p][2]) >>> 8)
                   + ofs[p];
        if (dist_neg < 0) v = VERDICT_INTERSECT;
      end
      return v;
    endfunction

    function void note_beat(cull_beat_t b);
      int k;
      if (b.action == ACTION_LOAD) begin
        // out-of-range plane index is dropped
        if (b.plane_index < PLANES) begin
          for (k = 0; k < 3; k++) nrm[b.plane_index][k] = longint'($signed(b.normal[k]));
          ofs[b.plane_index] = longint'($signed(b.offset));
        end
      end else begin
        verdict_q.push_back(classify_box(b));
      end
    endfunction

    function void check_verdict(logic [1:0] got);
      logic [1:0] want;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict beat: got %0d", got);
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict mismatch: expected %0d got %0d", want, got);
        end
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       action = ACTION_LOAD;
  logic [2:0] plane_index = '0;
  coord_t     normal_x = '0, normal_y = '0, normal_z = '0;
  offset_t    plane_offset = '0;
  coord_t     box_min_x = '0, box_min_y = '0, box_min_z = '0;
  coord_t     box_max_x = '0, box_max_y = '0, box_max_z = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] verdict;

  cull_scoreboard sb = new();
  logic calm = 1'b0;      // no new idle gaps start on either side while set
  int   beats_counted = 0;

  frustum_box_cull #(.PLANE_COUNT(PLANES)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .plane_index(plane_index),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .plane_offset(plane_offset),
    .box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
    .box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
    .out_valid(out_valid), .out_ready(out_ready), .verdict(verdict)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Coordinate biased toward the range ends
  function automatic coord_t pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'sh8000;
    if (r < 20) return 16'sh7fff;
    if (r < 25) return '0;
    return coord_t'($urandom());
  endfunction

  function automatic cull_beat_t noise_beat();
    cull_beat_t b;
    int k;
    b.action      = 1'($urandom_range(0, 1));
    b.plane_index = 3'($urandom_range(0, 7));
    for (k = 0; k < 3; k++) begin
      b.normal[k] = coord_t'($urandom());
      b.lo[k]     = coord_t'($urandom());
      b.hi[k]     = coord_t'($urandom());
    end
    b.offset = offset_t'($urandom());
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_beat(cull_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action       = b.action;
    plane_index  = b.plane_index;
    normal_x     = b.normal[0];
    normal_y     = b.normal[1];
    normal_z     = b.normal[2];
    plane_offset = b.offset;
    box_min_x    = b.lo[0];
    box_min_y    = b.lo[1];
    box_min_z    = b.lo[2];
    box_max_x    = b.hi[0];
    box_max_y    = b.hi[1];
    box_max_z    = b.hi[2];
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (b.action == ACTION_TEST || b.plane_index < PLANES) beats_counted++;
    @(negedge clk);
  endtask

  task automatic send_load(logic [2:0] idx, coord_t nx, coord_t ny, coord_t nz, offset_t ofs);
    cull_beat_t b;
    b             = noise_beat();
    b.action      = ACTION_LOAD;
    b.plane_index = idx;
    b.normal[0]   = nx;
    b.normal[1]   = ny;
    b.normal[2]   = nz;
    b.offset      = ofs;
    drive_beat(b);
  endtask

  task automatic send_test(coord_t lx, coord_t ly, coord_t lz,
                           coord_t hx, coord_t hy, coord_t hz);
    cull_beat_t b;
    b        = noise_beat();
    b.action = ACTION_TEST;
    b.lo[0]  = lx;
    b.lo[1]  = ly;
    b.lo[2]  = lz;
    b.hi[0]  = hx;
    b.hi[1]  = hy;
    b.hi[2]  = hz;
    drive_beat(b);
  endtask

  // Plane whose normal components mostly lie within one unit, with a moderate offset
  task automatic send_frustum_plane(logic [2:0] idx);
    coord_t n[3];
    int k;
    for (k = 0; k < 3; k++)
      n[k] = ($urandom_range(0, 4) == 0) ? coord_t'($urandom())
                                          : coord_t'($urandom_range(0, 512) - 256);
    send_load(idx, n[0], n[1], n[2], offset_t'($urandom_range(0, 20000) - 2000));
  endtask

  // Small box somewhere near the origin
  task automatic send_scene_box();
    int c[3], e[3];
    int k;
    for (k = 0; k < 3; k++) begin
      c[k] = $urandom_range(0, 6000) - 3000;
      e[k] = $urandom_range(0, 1500);
    end
    send_test(coord_t'(c[0] - e[0]), coord_t'(c[1] - e[1]), coord_t'(c[2] - e[2]),
              coord_t'(c[0] + e[0]), coord_t'(c[1] + e[1]), coord_t'(c[2] + e[2]));
  endtask

  // Input and output beats
  always @(posedge clk) begin : monitor
    cull_beat_t b;
    if (!rst) begin
      if (in_valid && in_ready) begin
        b.action      = action;
        b.plane_index = plane_index;
        b.normal[0]   = normal_x;
        b.normal[1]   = normal_y;
        b.normal[2]   = normal_z;
        b.offset      = plane_offset;
        b.lo[0]       = box_min_x;
        b.lo[1]       = box_min_y;
        b.lo[2]       = box_min_z;
        b.hi[0]       = box_max_x;
        b.hi[1]       = box_max_y;
        b.hi[2]       = box_max_z;
        sb.note_beat(b);
      end
      if (out_valid && out_ready) sb.check_verdict(verdict);
    end
  end

  // Output back-pressure
  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (out_ready && !calm && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        hold = pick_gap();
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("frustum_box_cull: mismatch");
    $finish;
  end

  initial begin : stimulus
    int i, n, r;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero planes, simple half-spaces, ignored indexes, extremes
    send_test(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_load(3'd0, 16'sd256, 16'sd0, 16'sd0, 32'sd0);
    send_test(16'sd100, 16'sd0, 16'sd0, 16'sd200, 16'sd5, 16'sd5);
    send_test(-16'sd200, 16'sd0, 16'sd0, -16'sd100, 16'sd5, 16'sd5);
    send_test(-16'sd100, 16'sd0, 16'sd0, 16'sd100, 16'sd5, 16'sd5);
    send_load(3'd7, -16'sd256, 16'sd0, 16'sd0, 32'h8000_0000);
    send_load(3'd5, -16'sd256, 16'sd9, 16'sd0, 32'h8000_0000);
    send_load(3'd6, 16'sd0, -16'sd256, 16'sd0, 32'h8000_0000);
    send_test(16'sd100, 16'sd0, 16'sd0, 16'sd200, 16'sd5, 16'sd5);
    send_load(3'd1, 16'sh8000, 16'sh8000, 16'sh8000, 32'h7fff_ffff);
    send_test(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_load(3'd2, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'h8000_0000);
    send_test(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_load(3'd2, 16'sd0, 16'sd0, 16'sd0, -32'sd1);
    send_test(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_load(3'd2, 16'sd0, 16'sd0, 16'sd0, 32'sd0);
    send_load(3'd3, 16'sd0, 16'sd256, -16'sd256, 32'sd50);
    send_load(3'd4, -16'sd1, 16'sd1, 16'sd0, 32'h7fff_ffff);
    // inverted box, degenerate boxes
    send_test(16'sd300, 16'sd300, 16'sd300, 16'sd10, 16'sd10, 16'sd10);
    send_test(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_test(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_test(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);

    // Random sessions: mostly a fresh frustum, then a run of boxes with stray loads; now and then noise beats
    while (beats_counted < BEAT_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(5, 15);
        for (i = 0; i < n; i++) drive_beat(noise_beat());
      end else begin
        for (i = 0; i < PLANES; i++) send_frustum_plane(i[2:0]);
        n = $urandom_range(20, 60);
        for (i = 0; i < n; i++) begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            send_load(3'($urandom_range(0, 7)), coord_t'($urandom()), coord_t'($urandom()),
                      coord_t'($urandom()), offset_t'($urandom()));
          end else if (r < 75) begin
            send_scene_box();
          end else begin
            send_test(pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord(), pick_coord());
          end
        end
      end
    end
    in_valid = 1'b0;
    calm = 1'b0;

    // Drain outstanding verdicts, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("frustum_box_cull: match");
    end else begin
      $display("frustum_box_cull: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fbc_pkg.sv
rtl/fbc_plane_store.sv
rtl/fbc_lane.sv
rtl/frustum_box_cull.sv
tb/tb.sv
